// File: sv/lin_frame_receiver_macros.svh
// Assertion macros for the LIN frame receiver checker.
`ifndef LIN_FRAME_RECEIVER_MACROS_SVH
`define LIN_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LFR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LFR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/lfr_pkg.sv
// Shared constants and types for the LIN frame receiver.
`default_nettype none

package lfr_pkg;

	localparam int BUFFER_BYTES = 9;
	localparam int DATA_BYTES   = 8;
	localparam int DATA_W       = 64;
	localparam int CNT_W        = 4;
	localparam int TICK_W       = 32;
	localparam int TMO_W        = 16;
	localparam int ID_W         = 6;

	localparam logic [CNT_W-1:0] MAX_DATA      = CNT_W'(DATA_BYTES);
	localparam logic [7:0]       BREAK_BYTE    = 8'h00;
	localparam logic [7:0]       SYNC_BYTE     = 8'h55;
	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd10;

	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	typedef enum logic [3:0] {
		PH_BREAK = 4'b0001,
		PH_SYNC  = 4'b0010,
		PH_PID   = 4'b0100,
		PH_DATA  = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SUM  = 3'b010,
		ST_DONE = 3'b100
	} seq_t;

endpackage

`default_nettype wire

// File: sv/lin_frame_receiver.sv
// LIN frame receiver: header tracking, data collection and serial checksum test.
`default_nettype none

// Takes one word per received UART byte or timeout check and returns exactly one
// result word for each. in_ready is high only while the sequencer is idle. Most
// words go from acceptance straight to the done state, which loads the result
// into the output register. A word that closes a checksum point (3, 5 or 9
// collected bytes, or a due timeout with 3 to 8 bytes) walks the buffered data
// bytes through the single end-around-carry adder, one byte a cycle, and then
// compares once per pass: classic pass first, enhanced pass only on a miss.
// The result sits in an output register, so the next word is taken while it waits.
module lin_frame_receiver (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire                           opcode,
	input  wire  [7:0]                    rx_byte,
	input  wire  [lfr_pkg::TICK_W-1:0]    now_ticks,
	input  wire  [lfr_pkg::TICK_W-1:0]    now_us,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic                          accepted,
	output logic                          frame_ready,
	output logic [lfr_pkg::ID_W-1:0]      frame_id,
	output logic [lfr_pkg::CNT_W-1:0]     data_count,
	output logic [lfr_pkg::DATA_W-1:0]    frame_data,
	output logic                          enhanced_checksum,
	output logic [lfr_pkg::TICK_W-1:0]    frame_stamp,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [lfr_pkg::TMO_W-1:0]     cfg_data
);
	import lfr_pkg::*;

	function automatic logic pid_ok(input logic [7:0] p);
		logic [5:0] id;
		logic       p0;
		logic       p1;
		id = p[5:0];
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return (p[6] == p0) && (p[7] == p1);
	endfunction

	// ones' complement style add: carry out wraps back in
	function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? (s[7:0] + 8'd1) : s[7:0];
	endfunction

	function automatic logic [DATA_W-1:0] mask_bytes(input logic [DATA_W-1:0] d,
		input logic [CNT_W-1:0] n);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int i = 0; i < DATA_BYTES; i++) begin
			if (CNT_W'(i) < n)
				m[i*8 +: 8] = d[i*8 +: 8];
		end
		return m;
	endfunction

	seq_t              seq_q;
	phase_t            phase_q;
	logic [7:0]        pid_q;
	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] data_q;
	logic [7:0]        last_q;
	logic [TICK_W-1:0] start_q;
	logic [TICK_W-1:0] last_time_q;
	logic [TMO_W-1:0]  timeout_q;

	logic [7:0]        sum_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  len_q;
	logic [7:0]        ck_q;
	logic              pass_q;

	logic              res_acc_q;
	logic              res_ready_q;
	logic [ID_W-1:0]   res_id_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic [DATA_W-1:0] res_data_q;
	logic              res_enh_q;
	logic [TICK_W-1:0] res_stamp_q;

	logic              out_valid_q;
	logic              o_acc_q;
	logic              o_ready_q;
	logic [ID_W-1:0]   o_id_q;
	logic [CNT_W-1:0]  o_cnt_q;
	logic [DATA_W-1:0] o_data_q;
	logic              o_enh_q;
	logic [TICK_W-1:0] o_stamp_q;

	logic [TICK_W-1:0] elapsed;
	logic              due;
	logic [CNT_W-1:0]  count_nxt;
	logic [7:0]        sum_byte;

	assign elapsed   = now_ticks - last_time_q;
	assign due       = elapsed >= {{(TICK_W-TMO_W){1'b0}}, timeout_q};
	assign count_nxt = count_q + CNT_W'(1);
	assign sum_byte  = data_q[{idx_q[2:0], 3'b000} +: 8];

	assign in_ready          = (seq_q == ST_IDLE);
	assign cfg_ready         = 1'b1;
	assign out_valid         = out_valid_q;
	assign accepted          = o_acc_q;
	assign frame_ready       = o_ready_q;
	assign frame_id          = o_id_q;
	assign data_count        = o_cnt_q;
	assign frame_data        = o_data_q;
	assign enhanced_checksum = o_enh_q;
	assign frame_stamp       = o_stamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= ST_IDLE;
			phase_q     <= PH_BREAK;
			pid_q       <= '0;
			count_q     <= '0;
			start_q     <= '0;
			last_time_q <= '0;
			timeout_q   <= TIMEOUT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				timeout_q <= cfg_data;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (seq_q)
				ST_IDLE: begin
					if (in_valid) begin
						seq_q       <= ST_DONE;
						res_acc_q   <= 1'b0;
						res_ready_q <= 1'b0;
						res_id_q    <= '0;
						res_cnt_q   <= '0;
						res_data_q  <= '0;
						res_enh_q   <= 1'b0;
						res_stamp_q <= '0;
						pass_q      <= 1'b0;
						sum_q       <= '0;
						idx_q       <= '0;
						if (opcode == OP_BYTE) begin
							last_time_q <= now_ticks;
							case (phase_q)
								PH_BREAK: begin
									if (rx_byte == BREAK_BYTE) begin
										phase_q   <= PH_SYNC;
										start_q   <= now_us;
										res_acc_q <= 1'b1;
									end
								end
								PH_SYNC: begin
									if (rx_byte == SYNC_BYTE) begin
										phase_q   <= PH_PID;
										res_acc_q <= 1'b1;
									end else begin
										phase_q <= PH_BREAK;
									end
								end
								PH_PID: begin
									if (pid_ok(rx_byte)) begin
										pid_q     <= rx_byte;
										count_q   <= '0;
										phase_q   <= PH_DATA;
										res_acc_q <= 1'b1;
									end else begin
										phase_q <= PH_BREAK;
									end
								end
								PH_DATA: begin
									if (count_q != '0 && last_q == BREAK_BYTE &&
										rx_byte == SYNC_BYTE) begin
										// new header inside the data: close as header only
										res_acc_q   <= 1'b1;
										res_ready_q <= 1'b1;
										res_id_q    <= pid_q[ID_W-1:0];
										res_stamp_q <= start_q;
										phase_q     <= PH_PID;
										count_q     <= '0;
										start_q     <= now_us;
									end else begin
										if (count_q < MAX_DATA)
											data_q[{count_q[2:0], 3'b000} +: 8] <= rx_byte;
										last_q    <= rx_byte;
										count_q   <= count_nxt;
										res_acc_q <= 1'b1;
										if (count_nxt inside {4'd3, 4'd5,
											CNT_W'(BUFFER_BYTES)}) begin
											len_q <= count_nxt - CNT_W'(1);
											ck_q  <= rx_byte;
											seq_q <= ST_SUM;
										end
									end
								end
								default: phase_q <= PH_BREAK;
							endcase
						end else if (phase_q != PH_BREAK && due) begin
							phase_q   <= PH_BREAK;
							res_acc_q <= 1'b1;
							if (phase_q == PH_DATA) begin
								if (count_q == '0) begin
									res_ready_q <= 1'b1;
									res_id_q    <= pid_q[ID_W-1:0];
									res_stamp_q <= start_q;
								end else if (count_q >= CNT_W'(3)) begin
									len_q <= count_q - CNT_W'(1);
									ck_q  <= last_q;
									seq_q <= ST_SUM;
								end
							end
						end
					end
				end
				ST_SUM: begin
					if (idx_q < len_q) begin
						sum_q <= eac_add(sum_q, sum_byte);
						idx_q <= idx_q + CNT_W'(1);
					end else if (~sum_q == ck_q) begin
						res_ready_q <= 1'b1;
						res_id_q    <= pid_q[ID_W-1:0];
						res_cnt_q   <= len_q;
						res_data_q  <= mask_bytes(data_q, len_q);
						res_enh_q   <= pass_q;
						res_stamp_q <= start_q;
						phase_q     <= PH_BREAK;
						seq_q       <= ST_DONE;
					end else if (!pass_q) begin
						// classic missed: rerun seeded with the PID
						pass_q <= 1'b1;
						sum_q  <= pid_q;
						idx_q  <= '0;
					end else begin
						// full buffer and no match drops the frame; a timeout already left
						if (phase_q == PH_DATA && len_q == MAX_DATA) begin
							phase_q   <= PH_BREAK;
							res_acc_q <= 1'b0;
						end
						seq_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						o_acc_q     <= res_acc_q;
						o_ready_q   <= res_ready_q;
						o_id_q      <= res_id_q;
						o_cnt_q     <= res_cnt_q;
						o_data_q    <= res_data_q;
						o_enh_q     <= res_enh_q;
						o_stamp_q   <= res_stamp_q;
						seq_q       <= ST_IDLE;
					end
				end
				default: seq_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/lfr_checker.sv
// Port-level assertions for the LIN frame receiver, bound to the top level.
`default_nettype none

`include "lin_frame_receiver_macros.svh"

module lfr_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           in_valid,
	input wire                           in_ready,
	input wire                           out_valid,
	input wire                           out_ready,
	input wire                           accepted,
	input wire                           frame_ready,
	input wire [lfr_pkg::ID_W-1:0]       frame_id,
	input wire [lfr_pkg::CNT_W-1:0]      data_count,
	input wire [lfr_pkg::DATA_W-1:0]     frame_data,
	input wire                           enhanced_checksum,
	input wire [lfr_pkg::TICK_W-1:0]     frame_stamp
);
	import lfr_pkg::*;

	`LFR_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(frame_data) && $stable(frame_stamp) && $stable(accepted),
		"stalled result word changed")

	`LFR_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready,
		"word taken while the previous one was still in work")

	`LFR_ASSERT_IMP(a_quiet_fields, out_valid && !frame_ready,
		frame_id == '0 && data_count == '0 && frame_data == '0 &&
		!enhanced_checksum && frame_stamp == '0,
		"frame fields set without a frame")

	`LFR_ASSERT_IMP(a_frame_accepted, out_valid && frame_ready,
		accepted && data_count <= MAX_DATA,
		"frame reported on a rejected word or with too many bytes")

	`LFR_ASSERT_IMP(a_header_only, out_valid && frame_ready && data_count == '0,
		!enhanced_checksum && frame_data == '0,
		"header-only frame carries data or checksum type")

endmodule

bind lin_frame_receiver lfr_checker u_lfr_checker (.*);

`default_nettype wire
